// File: sv/nearest_point_on_cubic_path_unit_assert.svh
// Assertion macros for the nearest point on cubic path unit
`ifndef NEAREST_POINT_ON_CUBIC_PATH_UNIT_ASSERT_SVH
`define NEAREST_POINT_ON_CUBIC_PATH_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define NPCP_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define NPCP_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/npcp_pkg.sv
// Package: types, constants and tables of the nearest point on cubic path unit
package npcp_pkg;

	localparam int SAMPLES_DEF      = 10;
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int ITER_W           = 5;

	localparam logic [3:0] STEP_X3  = 4'd0;
	localparam logic [3:0] STEP_Y3  = 4'd1;
	localparam logic [3:0] STEP_X2  = 4'd2;
	localparam logic [3:0] STEP_Y2  = 4'd3;
	localparam logic [3:0] STEP_X1  = 4'd4;
	localparam logic [3:0] STEP_Y1  = 4'd5;
	localparam logic [3:0] STEP_X0  = 4'd6;
	localparam logic [3:0] STEP_Y0  = 4'd7;
	localparam logic [3:0] STEP_SQY = 4'd8;
	localparam logic [3:0] STEP_CMP = 4'd9;

	typedef struct packed {
		logic signed [31:0] coef_x3;
		logic signed [31:0] coef_x2;
		logic signed [31:0] coef_x1;
		logic signed [31:0] coef_x0;
		logic signed [31:0] coef_y3;
		logic signed [31:0] coef_y2;
		logic signed [31:0] coef_y1;
		logic signed [31:0] coef_y0;
		logic [15:0]        segment_id;
		logic               last_segment;
		logic signed [31:0] car_x;
		logic signed [31:0] car_y;
	} item_t;

	typedef struct packed {
		logic [15:0]        best_segment_id;
		logic [16:0]        best_param;
		logic signed [31:0] nearest_x;
		logic signed [31:0] nearest_y;
		logic [15:0]        heading;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SAMPLE,
		ST_DERIV,
		ST_CORDIC,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic              load_item;
		logic              open_query;
		logic              deriv;
		logic [3:0]        step;
		logic              p_clear;
		logic              p_next;
		logic              take_first;
		logic              cordic_init;
		logic              cordic_iter;
		logic [ITER_W-1:0] iter;
		logic              out_load;
	} cmd_t;

	typedef struct packed {
		logic last_segment;
	} status_t;

	function automatic logic signed [36:0] ext37(logic signed [31:0] v);
		return {{5{v[31]}}, v};
	endfunction

	function automatic logic signed [31:0] sat32(logic signed [36:0] v);
		if (v > 37'sd2147483647)
			return 32'sh7fffffff;
		else if (v < -37'sd2147483648)
			return 32'sh80000000;
		else
			return v[31:0];
	endfunction

	function automatic logic [31:0] angle_of(logic [ITER_W-1:0] i);
		case (i)
			5'd0:    return 32'd536870912;
			5'd1:    return 32'd316933406;
			5'd2:    return 32'd167458907;
			5'd3:    return 32'd85004756;
			5'd4:    return 32'd42667331;
			5'd5:    return 32'd21354465;
			5'd6:    return 32'd10679838;
			5'd7:    return 32'd5340245;
			5'd8:    return 32'd2670163;
			5'd9:    return 32'd1335087;
			5'd10:   return 32'd667544;
			5'd11:   return 32'd333772;
			5'd12:   return 32'd166886;
			5'd13:   return 32'd83443;
			5'd14:   return 32'd41722;
			5'd15:   return 32'd20861;
			5'd16:   return 32'd10430;
			5'd17:   return 32'd5215;
			5'd18:   return 32'd2608;
			5'd19:   return 32'd1304;
			5'd20:   return 32'd652;
			5'd21:   return 32'd326;
			5'd22:   return 32'd163;
			5'd23:   return 32'd81;
			default: return 32'd0;
		endcase
	endfunction

endpackage

// File: sv/npcp_if.sv
// Channel interfaces: path segment items in, nearest point results out
interface npcp_seg_if;
	logic            valid;
	logic            ready;
	npcp_pkg::item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface npcp_res_if;
	logic              valid;
	logic              ready;
	npcp_pkg::result_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// File: sv/npcp_ctrl.sv
// Controller: sequences samples, derivative, CORDIC and result hand-off
module npcp_ctrl #(
	parameter int SAMPLES      = npcp_pkg::SAMPLES_DEF,
	parameter int CORDIC_STEPS = npcp_pkg::CORDIC_STEPS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              seg_valid,
	output logic              seg_ready,
	output logic              res_valid,
	input  logic              res_ready,
	output npcp_pkg::cmd_t    cmd,
	input  npcp_pkg::status_t status
);
	import npcp_pkg::*;

	localparam int JW = $clog2(SAMPLES + 1);

	state_t            state_q, state_d;
	logic [3:0]        step_q, step_d;
	logic [JW-1:0]     j_q, j_d;
	logic [ITER_W-1:0] iter_q, iter_d;
	logic              open_q, first_q, res_valid_q;
	logic              accept, last_j, emit_go;

	assign accept  = seg_valid && seg_ready;
	assign last_j  = (j_q == JW'(SAMPLES));
	assign emit_go = (state_q == ST_EMIT) && (!res_valid_q || res_ready);

	always_comb begin
		state_d = state_q;
		step_d  = step_q;
		j_d     = j_q;
		iter_d  = iter_q;
		unique case (state_q)
			ST_IDLE: begin
				if (seg_valid) begin
					state_d = ST_SAMPLE;
					step_d  = STEP_X3;
					j_d     = '0;
				end
			end
			ST_SAMPLE: begin
				if (step_q == STEP_CMP) begin
					step_d = STEP_X3;
					if (last_j) begin
						state_d = status.last_segment ? ST_DERIV : ST_IDLE;
					end else begin
						j_d = j_q + 1'b1;
					end
				end else begin
					step_d = step_q + 1'b1;
				end
			end
			ST_DERIV: begin
				if (step_q == STEP_X0) begin
					state_d = ST_CORDIC;
					iter_d  = '0;
				end else begin
					step_d = step_q + 1'b1;
				end
			end
			ST_CORDIC: begin
				if (iter_q == ITER_W'(CORDIC_STEPS - 1)) begin
					state_d = ST_EMIT;
				end else begin
					iter_d = iter_q + 1'b1;
				end
			end
			ST_EMIT: begin
				if (emit_go) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		seg_ready       = (state_q == ST_IDLE);
		cmd             = '0;
		cmd.load_item   = accept;
		cmd.open_query  = accept && !open_q;
		cmd.p_clear     = accept;
		cmd.step        = step_q;
		cmd.iter        = iter_q;
		cmd.deriv       = (state_q == ST_DERIV);
		cmd.p_next      = (state_q == ST_SAMPLE) && (step_q == STEP_CMP);
		cmd.take_first  = first_q && (j_q == '0);
		cmd.cordic_init = (state_q == ST_DERIV) && (step_q == STEP_X0);
		cmd.cordic_iter = (state_q == ST_CORDIC);
		cmd.out_load    = emit_go;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			j_q         <= '0;
			iter_q      <= '0;
			open_q      <= 1'b0;
			first_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			j_q     <= j_d;
			iter_q  <= iter_d;
			if (accept) begin
				first_q <= !open_q;
				open_q  <= 1'b1;
			end else if (emit_go) begin
				open_q <= 1'b0;
			end
			if (emit_go)
				res_valid_q <= 1'b1;
			else if (res_ready)
				res_valid_q <= 1'b0;
		end
	end

	assign res_valid = res_valid_q;

endmodule

// File: sv/npcp_dp.sv
// Datapath: shared multiplier, Horner evaluation, distance compare, CORDIC
module npcp_dp #(
	parameter int SAMPLES = npcp_pkg::SAMPLES_DEF
) (
	input  logic              clk,
	input  npcp_pkg::item_t   item,
	input  npcp_pkg::cmd_t    cmd,
	output npcp_pkg::status_t status,
	output npcp_pkg::result_t res
);
	import npcp_pkg::*;

	localparam int         RW     = $clog2(SAMPLES + 1);
	localparam logic [16:0] P_STEP = 17'(65536 / SAMPLES);
	localparam logic [RW-1:0] P_REM = RW'(65536 % SAMPLES);

	item_t              it_q;
	logic signed [31:0] car_x_q, car_y_q;
	logic [16:0]        p_q;
	logic [RW-1:0]      r_q;
	logic [RW:0]        r_sum;

	logic signed [70:0] prod_q;
	logic signed [36:0] fl_q;
	logic signed [36:0] mul_a, addend, fl, hsum;
	logic signed [33:0] mul_b;
	logic [16:0]        p_use;

	logic signed [31:0] px_q, py_q;
	logic signed [32:0] ex, ey;
	logic [63:0]        sq_q, dist_sat;
	logic [64:0]        dsum;
	logic               upd;

	logic [63:0]        best_dist_q;
	logic [15:0]        best_id_q;
	logic [16:0]        best_p_q;
	logic signed [31:0] best_px_q, best_py_q;
	logic signed [31:0] bx3_q, bx2_q, bx1_q, by3_q, by2_q, by1_q;

	logic signed [36:0] dx_q, dy_q;
	logic signed [59:0] cx_q, cy_q, cx_i, cy_i, xs, ys;
	logic [31:0]        ang_q, hround;
	logic               zero_q;

	assign r_sum = {1'b0, r_q} + {1'b0, P_REM};

	always_ff @(posedge clk) begin
		if (cmd.load_item)
			it_q <= item;
		if (cmd.open_query) begin
			car_x_q <= item.car_x;
			car_y_q <= item.car_y;
		end
		if (cmd.p_clear) begin
			p_q <= '0;
			r_q <= '0;
		end else if (cmd.p_next) begin
			if (r_sum >= (RW+1)'(SAMPLES)) begin
				r_q <= RW'(r_sum - (RW+1)'(SAMPLES));
				p_q <= p_q + P_STEP + 17'd1;
			end else begin
				r_q <= r_sum[RW-1:0];
				p_q <= p_q + P_STEP;
			end
		end
	end

	assign p_use = cmd.deriv ? best_p_q : p_q;
	assign fl    = fl_q;
	assign hsum  = fl + addend;
	assign ex    = {px_q[31], px_q} - {car_x_q[31], car_x_q};
	assign ey    = {py_q[31], py_q} - {car_y_q[31], car_y_q};

	always_comb begin
		addend = '0;
		if (cmd.deriv) begin
			unique case (cmd.step)
				STEP_X2: addend = ext37(bx2_q) <<< 1;
				STEP_Y2: addend = ext37(by2_q) <<< 1;
				STEP_X1: addend = ext37(bx1_q);
				STEP_Y1: addend = ext37(by1_q);
				default: addend = '0;
			endcase
		end else begin
			unique case (cmd.step)
				STEP_X2: addend = ext37(it_q.coef_x2);
				STEP_Y2: addend = ext37(it_q.coef_y2);
				STEP_X1: addend = ext37(it_q.coef_x1);
				STEP_Y1: addend = ext37(it_q.coef_y1);
				STEP_X0: addend = ext37(it_q.coef_x0);
				STEP_Y0: addend = ext37(it_q.coef_y0);
				default: addend = '0;
			endcase
		end
	end

	always_comb begin
		mul_a = hsum;
		mul_b = {17'd0, p_use};
		if (cmd.deriv) begin
			unique case (cmd.step)
				STEP_X3: mul_a = (ext37(bx3_q) <<< 1) + ext37(bx3_q);
				STEP_Y3: mul_a = (ext37(by3_q) <<< 1) + ext37(by3_q);
				default: mul_a = hsum;
			endcase
		end else begin
			unique case (cmd.step)
				STEP_X3: mul_a = ext37(it_q.coef_x3);
				STEP_Y3: mul_a = ext37(it_q.coef_y3);
				STEP_Y0: begin
					mul_a = {{4{ex[32]}}, ex};
					mul_b = {ex[32], ex};
				end
				STEP_SQY: begin
					mul_a = {{4{ey[32]}}, ey};
					mul_b = {ey[32], ey};
				end
				default: mul_a = hsum;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		fl_q   <= prod_q[52:16];
	end

	assign dsum     = {1'b0, sq_q} + {1'b0, prod_q[63:0]};
	assign dist_sat = dsum[64] ? '1 : dsum[63:0];
	assign upd      = !cmd.deriv && (cmd.step == STEP_CMP) &&
		(cmd.take_first || (dist_sat < best_dist_q));

	always_ff @(posedge clk) begin
		if (!cmd.deriv && cmd.step == STEP_X0)
			px_q <= sat32(hsum);
		if (!cmd.deriv && cmd.step == STEP_Y0)
			py_q <= sat32(hsum);
		if (!cmd.deriv && cmd.step == STEP_SQY)
			sq_q <= prod_q[63:0];
		if (cmd.deriv && cmd.step == STEP_X1)
			dx_q <= hsum;
		if (cmd.deriv && cmd.step == STEP_Y1)
			dy_q <= hsum;
		if (cmd.open_query) begin
			best_dist_q <= '1;
		end else if (upd) begin
			best_dist_q <= dist_sat;
			best_id_q   <= it_q.segment_id;
			best_p_q    <= p_q;
			best_px_q   <= px_q;
			best_py_q   <= py_q;
			bx3_q       <= it_q.coef_x3;
			bx2_q       <= it_q.coef_x2;
			bx1_q       <= it_q.coef_x1;
			by3_q       <= it_q.coef_y3;
			by2_q       <= it_q.coef_y2;
			by1_q       <= it_q.coef_y1;
		end
	end

	assign cx_i = {{3{dx_q[36]}}, dx_q, 20'd0};
	assign cy_i = {{3{dy_q[36]}}, dy_q, 20'd0};
	assign xs   = cx_q >>> cmd.iter;
	assign ys   = cy_q >>> cmd.iter;

	always_ff @(posedge clk) begin
		if (cmd.cordic_init) begin
			zero_q <= (dx_q == '0) && (dy_q == '0);
			if (dx_q[36]) begin
				cx_q  <= -cx_i;
				cy_q  <= -cy_i;
				ang_q <= 32'h8000_0000;
			end else begin
				cx_q  <= cx_i;
				cy_q  <= cy_i;
				ang_q <= '0;
			end
		end else if (cmd.cordic_iter) begin
			if (!cy_q[59]) begin
				cx_q  <= cx_q + ys;
				cy_q  <= cy_q - xs;
				ang_q <= ang_q + angle_of(cmd.iter);
			end else begin
				cx_q  <= cx_q - ys;
				cy_q  <= cy_q + xs;
				ang_q <= ang_q - angle_of(cmd.iter);
			end
		end
	end

	assign hround = ang_q + 32'h0000_8000;

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res.best_segment_id <= best_id_q;
			res.best_param      <= best_p_q;
			res.nearest_x       <= best_px_q;
			res.nearest_y       <= best_py_q;
			res.heading         <= zero_q ? 16'd0 : hround[31:16];
		end
	end

	assign status.last_segment = it_q.last_segment;

endmodule

// File: sv/nearest_point_on_cubic_path_unit.sv
// Top level: nearest sampled point on a chain of cubic path segments
//
//   channel   dir  handshake     payload
//   segment   in   valid/ready   npcp_pkg::item_t
//   result    out  valid/ready   npcp_pkg::result_t
//
// A segment is evaluated at SAMPLES+1 sample points, ten steps per sample point
// through the one shared multiplier. A last segment adds the derivative steps,
// CORDIC_STEPS iterations of the iterative CORDIC and the load of the result.
// Reset clears the controller; a result waits in its register until taken and
// a new segment is accepted meanwhile, stalling only when the next result is ready.
module nearest_point_on_cubic_path_unit #(
	parameter int SAMPLES      = npcp_pkg::SAMPLES_DEF,
	parameter int CORDIC_STEPS = npcp_pkg::CORDIC_STEPS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	npcp_seg_if.sink   segment,
	npcp_res_if.source result
);
	import npcp_pkg::*;

	cmd_t    cmd;
	status_t status;

	npcp_ctrl #(
		.SAMPLES      (SAMPLES),
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.seg_valid (segment.valid),
		.seg_ready (segment.ready),
		.res_valid (result.valid),
		.res_ready (result.ready),
		.cmd       (cmd),
		.status    (status)
	);

	npcp_dp #(
		.SAMPLES (SAMPLES)
	) u_dp (
		.clk    (clk),
		.item   (segment.data),
		.cmd    (cmd),
		.status (status),
		.res    (result.data)
	);

endmodule

// File: sv/npcp_checker.sv
// Checker on the top level ports, bound to the nearest point unit
`include "nearest_point_on_cubic_path_unit_assert.svh"

module npcp_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              seg_valid,
	input logic              seg_ready,
	input logic              res_valid,
	input logic              res_ready,
	input npcp_pkg::result_t res_data
);
	import npcp_pkg::*;

	`NPCP_ASSERT_NXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_data), "result item dropped or changed while stalled")
	`NPCP_ASSERT_NXT(a_busy_after_accept, seg_valid && seg_ready, !seg_ready, "segment accepted while previous item still at work")
	`NPCP_ASSERT_IMP(a_param_range, res_valid, res_data.best_param <= 17'd65536, "best_param above 1.0")

endmodule

bind nearest_point_on_cubic_path_unit npcp_checker u_npcp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.seg_valid (segment.valid),
	.seg_ready (segment.ready),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.res_data  (result.data)
);

// File: tb/testbench.sv
// Testbench for the nearest point on cubic path unit: predicted results vs. actual
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import npcp_pkg::*;

	localparam int SAMPLES      = SAMPLES_DEF;
	localparam int CORDIC_STEPS = CORDIC_STEPS_DEF;
	localparam longint CYCLE_LIMIT = 4000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	npcp_seg_if seg_ch ();
	npcp_res_if res_ch ();

	nearest_point_on_cubic_path_unit #(.SAMPLES(SAMPLES), .CORDIC_STEPS(CORDIC_STEPS)) dut (
		.clk(clk), .arst_n(arst_n), .segment(seg_ch.sink), .result(res_ch.source)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// path tracking state
	bit                 query_open;
	logic signed [31:0] car_hold_x, car_hold_y;
	logic [63:0]        nearest_dist;
	logic [15:0]        nearest_id;
	int unsigned        nearest_idx;
	logic signed [31:0] nearest_px, nearest_py;
	logic signed [63:0] tangent_x, tangent_y;

	result_t     nearest_q[$];
	int          mismatches;
	int          send_idle_pct, recv_stall_pct;
	bit          hold_off;
	longint      cycles;

	function automatic logic signed [63:0] scale_down(logic signed [63:0] v);
		return v >>> 16;
	endfunction

	function automatic logic [16:0] sample_param(int unsigned j);
		return 17'((longint'(j) << 16) / SAMPLES);
	endfunction

	function automatic logic signed [63:0] poly_at(logic signed [63:0] a, logic signed [63:0] b,
			logic signed [63:0] c, logic signed [63:0] d, logic signed [63:0] p);
		logic signed [63:0] acc;
		acc = a;
		acc = scale_down(acc * p) + b;
		acc = scale_down(acc * p) + c;
		acc = scale_down(acc * p) + d;
		return acc;
	endfunction

	function automatic logic signed [63:0] slope_at(logic signed [63:0] a, logic signed [63:0] b,
			logic signed [63:0] c, logic signed [63:0] p);
		logic signed [63:0] acc;
		acc = a;
		acc = scale_down(acc * p) + b;
		acc = scale_down(acc * p) + c;
		return acc;
	endfunction

	function automatic logic signed [31:0] clamp32(logic signed [63:0] v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic logic [31:0] cordic_angle(int i);
		logic [31:0] tab [24];
		tab = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
			10679838, 5340245, 2670163, 1335087, 667544, 333772,
			166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
		return tab[i];
	endfunction

	function automatic logic [15:0] tangent_heading(logic signed [63:0] dx, logic signed [63:0] dy);
		logic signed [63:0] x, y, xs, ys;
		logic [31:0] ang;
		logic [32:0] rnd;
		if (dx == 0 && dy == 0) return 16'd0;
		x = dx <<< 20;
		y = dy <<< 20;
		ang = 32'd0;
		if (x < 0) begin
			x = -x;
			y = -y;
			ang = 32'h80000000;
		end
		for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
				ang = ang + cordic_angle(i);
			end else begin
				x = x - ys;
				y = y + xs;
				ang = ang - cordic_angle(i);
			end
		end
		rnd = {1'b0, ang} + 33'h8000;
		return rnd[31:16];
	endfunction

	task automatic track_segment(item_t it);
		bit first;
		logic signed [63:0] p, ex, ey;
		logic signed [31:0] px, py;
		logic [63:0] sx, sy, d;
		result_t r;
		first = 1'b0;
		if (!query_open) begin
			car_hold_x = it.car_x;
			car_hold_y = it.car_y;
			nearest_dist = '1;
			query_open = 1'b1;
			first = 1'b1;
		end
		for (int unsigned j = 0; j <= SAMPLES; j++) begin
			p = 64'(sample_param(j));
			px = clamp32(poly_at(it.coef_x3, it.coef_x2, it.coef_x1, it.coef_x0, p));
			py = clamp32(poly_at(it.coef_y3, it.coef_y2, it.coef_y1, it.coef_y0, p));
			ex = 64'(px) - 64'(car_hold_x);
			ey = 64'(py) - 64'(car_hold_y);
			if (ex < 0) ex = -ex;
			if (ey < 0) ey = -ey;
			sx = ex * ex;
			sy = ey * ey;
			d = (sx > ~sy) ? '1 : sx + sy;
			if ((first && j == 0) || d < nearest_dist) begin
				nearest_dist = d;
				nearest_id = it.segment_id;
				nearest_idx = j;
				nearest_px = px;
				nearest_py = py;
				tangent_x = slope_at(3 * 64'(it.coef_x3), 2 * 64'(it.coef_x2), it.coef_x1, p);
				tangent_y = slope_at(3 * 64'(it.coef_y3), 2 * 64'(it.coef_y2), it.coef_y1, p);
			end
		end
		if (it.last_segment) begin
			r.best_segment_id = nearest_id;
			r.best_param = sample_param(nearest_idx);
			r.nearest_x = nearest_px;
			r.nearest_y = nearest_py;
			r.heading = tangent_heading(tangent_x, tangent_y);
			nearest_q.push_back(r);
			query_open = 1'b0;
		end
	endtask

	task automatic send_segment(item_t it);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			seg_ch.valid <= 1'b0;
			@(posedge clk);
		end
		seg_ch.valid <= 1'b1;
		seg_ch.data <= it;
		@(posedge clk);
		while (!seg_ch.ready) @(posedge clk);
		track_segment(it);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) begin
				if (nearest_q.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected result %p", res_ch.data);
					mismatches++;
				end else begin
					if (res_ch.data !== nearest_q[0]) begin
						if (mismatches < 10)
							$display("mismatch: expected %p actual %p", nearest_q[0], res_ch.data);
						mismatches++;
					end
					void'(nearest_q.pop_front());
				end
			end
			res_ch.ready <= !hold_off && !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("nearest_point_on_cubic_path_unit regression: fail");
			$finish;
		end
	end

	function automatic logic signed [31:0] rand_coef();
		case ($urandom_range(5))
			0: return $urandom;
			1: return 32'sh7fffffff;
			2: return 32'sh80000000;
			default: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
		endcase
	endfunction

	function automatic item_t random_segment(bit last);
		item_t it;
		it.coef_x3 = rand_coef(); it.coef_x2 = rand_coef();
		it.coef_x1 = rand_coef(); it.coef_x0 = rand_coef();
		it.coef_y3 = rand_coef(); it.coef_y2 = rand_coef();
		it.coef_y1 = rand_coef(); it.coef_y0 = rand_coef();
		it.segment_id = $urandom;
		it.last_segment = last;
		it.car_x = rand_coef();
		it.car_y = rand_coef();
		return it;
	endfunction

	task automatic test_directed();
		item_t it;
		it = '0;
		it.last_segment = 1'b1;
		send_segment(it);
		it = '1;
		send_segment(it);
		it = '0;
		it.coef_x3 = 32'sh7fffffff; it.coef_x2 = 32'sh7fffffff;
		it.coef_x1 = 32'sh7fffffff; it.coef_x0 = 32'sh7fffffff;
		it.coef_y3 = 32'sh80000000; it.coef_y2 = 32'sh80000000;
		it.coef_y1 = 32'sh80000000; it.coef_y0 = 32'sh80000000;
		it.car_x = 32'sh80000000; it.car_y = 32'sh7fffffff;
		it.segment_id = 16'hffff;
		it.last_segment = 1'b1;
		send_segment(it);
		// equal distance on two segments: earlier keeps
		it = '0;
		it.coef_x0 = 32'sh10000;
		it.segment_id = 16'd1;
		send_segment(it);
		it.segment_id = 16'd2;
		it.last_segment = 1'b1;
		send_segment(it);
		// straight lines at several headings, one shrunk to a point, and one cubic curve
		for (int k = 0; k < 8; k++) begin
			it = '0;
			it.coef_x1 = (k % 3 - 1) * 32'sh10000;
			it.coef_y1 = ((k / 3) % 3 - 1) * 32'sh10000;
			it.coef_x3 = (k == 7) ? -32'sh8000 : 32'sh0;
			it.car_x = 32'sh4000;
			it.segment_id = 16'(k);
			it.last_segment = 1'b1;
			send_segment(it);
		end
		for (int k = 0; k < 8; k++)
			send_segment(random_segment(k % 3 == 2));
	endtask

	task automatic test_random(int n);
		int left;
		left = n;
		while (left > 0) begin
			int len;
			len = $urandom_range(1, 4);
			for (int k = 0; k < len && left > 0; k++) begin
				send_segment(random_segment(k == len - 1));
				left--;
			end
		end
	endtask

	task automatic test_backpressure();
		fork
			begin
				hold_off = 1'b1;
				repeat (2000) @(posedge clk);
				hold_off = 1'b0;
			end
			for (int k = 0; k < 12; k++)
				send_segment(random_segment(1'b1));
		join
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		seg_ch.valid <= 1'b0;
		while (nearest_q.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (300) @(posedge clk);
	endtask

	initial begin
		seg_ch.valid = 1'b0;
		seg_ch.data = '0;
		res_ch.ready = 1'b0;
		hold_off = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_random(400);
		send_idle_pct = 48;
		test_random(400);
		send_idle_pct = 0;
		recv_stall_pct = 48;
		test_random(400);
		send_idle_pct = 18;
		recv_stall_pct = 18;
		test_random(400);
		drain();
		if (mismatches == 0 && nearest_q.size() == 0)
			$display("nearest_point_on_cubic_path_unit regression: pass");
		else
			$display("nearest_point_on_cubic_path_unit regression: fail");
		$finish;
	end
endmodule

// File: files.f
+incdir+sv
sv/npcp_pkg.sv
sv/npcp_if.sv
sv/npcp_ctrl.sv
sv/npcp_dp.sv
sv/nearest_point_on_cubic_path_unit.sv
sv/npcp_checker.sv
tb/testbench.sv
